### src/nbc_pkg.sv
// Shared constants, command codes and the operation word passed from front to back.
package nbc_pkg;

  localparam int COUNT_BITS = 32;
  localparam int READ_BITS = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_EOL = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [4:0] IDX_BASE_FIRST = 5'd0;
  localparam logic [4:0] IDX_BASE_LAST = 5'd3;
  localparam logic [4:0] IDX_PAIR_FIRST = 5'd4;
  localparam logic [4:0] IDX_PAIR_LAST = 5'd19;
  localparam logic [4:0] IDX_BASE_TOTAL = 5'd20;
  localparam logic [4:0] IDX_PAIR_TOTAL = 5'd21;
  localparam logic [4:0] IDX_LINE_TOTAL = 5'd22;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic       clear;
    logic       base_en;
    logic [1:0] base_code;
    logic       pair_en;
    logic [3:0] pair_code;
    logic       line_en;
    logic       rd_en;
    logic [4:0] rd_idx;
  } op_t;

endpackage

### src/nucleotide_bigram_counter_core.sv
// Top level of the nucleotide and bigram counter: front end, queue and counter back end.
//
//   Channel  Handshake             Word fields
//   input    in_valid, in_stall    cmd, char_byte, counter_index
//   output   out_valid, out_stall  read_value, index_ok
//
// One input word is taken per cycle when the queue has room, and every input
// word yields exactly one output word. An accepted word is written into the
// queue, moves to the registered output once that is free, and leaves there
// when out_stall is low.
// Reset clears all counters and the held nucleotide.
// A stall on the output fills the two-entry queue, after which in_stall rises.
module nucleotide_bigram_counter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  char_byte,
  input  logic [4:0]  counter_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_value,
  output logic        index_ok
);
  import nbc_pkg::*;

  op_t  push_op;
  op_t  pop_op;
  logic push;
  logic pop;
  logic full;
  logic nonempty;

  nbc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .char_byte     (char_byte),
    .counter_index (counter_index),
    .full          (full),
    .push          (push),
    .op            (push_op)
  );

  nbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_op  (push_op),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .pop_op   (pop_op)
  );

  nbc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .nonempty   (nonempty),
    .op         (pop_op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .index_ok   (index_ok)
  );

endmodule

### src/nbc_front.sv
// Front end: accepts input words, decodes bytes and tracks the held nucleotide and line state.
module nbc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     cmd,
  input  logic [7:0]     char_byte,
  input  logic [4:0]     counter_index,
  input  logic           full,
  output logic           push,
  output nbc_pkg::op_t   op
);
  import nbc_pkg::*;

  logic       held_valid;
  logic [1:0] held_code;
  logic       line_has_chars;
  logic       held_valid_next;
  logic [1:0] held_code_next;
  logic       line_has_chars_next;
  logic       is_nuc;
  logic [1:0] code;

  always_comb begin
    is_nuc = 1'b1;
    code = 2'd0;
    unique case (char_byte)
      8'h41, 8'h61: code = 2'd0;
      8'h43, 8'h63: code = 2'd1;
      8'h47, 8'h67: code = 2'd2;
      8'h54, 8'h74: code = 2'd3;
      default: is_nuc = 1'b0;
    endcase
  end

  assign in_stall = full;
  assign push = in_valid && !full;

  always_comb begin
    op = '0;
    op.rd_idx = counter_index;
    op.base_code = code;
    op.pair_code = {held_code, code};
    held_valid_next = held_valid;
    held_code_next = held_code;
    line_has_chars_next = line_has_chars;
    unique case (cmd)
      CMD_CHAR: begin
        line_has_chars_next = 1'b1;
        op.base_en = is_nuc;
        op.pair_en = is_nuc && held_valid;
        if (is_nuc && !held_valid) begin
          held_valid_next = 1'b1;
          held_code_next = code;
        end else begin
          held_valid_next = 1'b0;
        end
      end
      CMD_EOL: begin
        op.line_en = line_has_chars;
        held_valid_next = 1'b0;
        line_has_chars_next = 1'b0;
      end
      CMD_READ: begin
        op.rd_en = 1'b1;
      end
      CMD_CLEAR: begin
        op.clear = 1'b1;
        held_valid_next = 1'b0;
        held_code_next = 2'd0;
        line_has_chars_next = 1'b0;
      end
      default: begin
        op.clear = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_code <= 2'd0;
      line_has_chars <= 1'b0;
    end else if (push) begin
      held_valid <= held_valid_next;
      held_code <= held_code_next;
      line_has_chars <= line_has_chars_next;
    end
  end

endmodule

### src/nbc_queue.sv
// Short queue of operation words between the front end and the counter back end.
module nbc_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  nbc_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         nonempty,
  output nbc_pkg::op_t pop_op
);
  import nbc_pkg::*;

  op_t                       slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   fill;

  assign full = (fill == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign nonempty = (fill != '0);
  assign pop_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### src/nbc_back.sv
// Back end: saturating counters, counter readout and the registered result word.
module nbc_back (
  input  logic         clk,
  input  logic         rst,
  input  logic         nonempty,
  input  nbc_pkg::op_t op,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [31:0]  read_value,
  output logic         index_ok
);
  import nbc_pkg::*;

  localparam int SEL_BITS = (COUNT_BITS < READ_BITS) ? COUNT_BITS : READ_BITS;

  count_t base_cnt [4];
  count_t pair_cnt [16];
  count_t base_total;
  count_t pair_total;
  count_t line_total;
  count_t sel;
  logic   sel_ok;

  function automatic count_t sat_inc(input count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  assign pop = nonempty && (!out_valid || !out_stall);

  always_comb begin
    sel = '0;
    sel_ok = 1'b1;
    unique case (op.rd_idx) inside
      [IDX_BASE_FIRST:IDX_BASE_LAST]: sel = base_cnt[op.rd_idx[1:0]];
      [IDX_PAIR_FIRST:IDX_PAIR_LAST]: sel = pair_cnt[4'(op.rd_idx - IDX_PAIR_FIRST)];
      IDX_BASE_TOTAL: sel = base_total;
      IDX_PAIR_TOTAL: sel = pair_total;
      IDX_LINE_TOTAL: sel = line_total;
      default: sel_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && op.clear)) begin
      for (int i = 0; i < 4; i++) begin
        base_cnt[i] <= '0;
      end
      for (int i = 0; i < 16; i++) begin
        pair_cnt[i] <= '0;
      end
      base_total <= '0;
      pair_total <= '0;
      line_total <= '0;
    end else if (pop) begin
      for (int i = 0; i < 4; i++) begin
        if (op.base_en && op.base_code == 2'(i)) begin
          base_cnt[i] <= sat_inc(base_cnt[i]);
        end
      end
      for (int i = 0; i < 16; i++) begin
        if (op.pair_en && op.pair_code == 4'(i)) begin
          pair_cnt[i] <= sat_inc(pair_cnt[i]);
        end
      end
      if (op.base_en) begin
        base_total <= sat_inc(base_total);
      end
      if (op.pair_en) begin
        pair_total <= sat_inc(pair_total);
      end
      if (op.line_en) begin
        line_total <= sat_inc(line_total);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      read_value <= (op.rd_en && sel_ok) ? 32'(sel[SEL_BITS-1:0]) : 32'd0;
      index_ok <= op.rd_en && sel_ok;
    end
  end

endmodule
